>>> hdl/quc_pkg.sv
// ----------------------------------------------------------------------------
// quc_pkg
// Shared types, constants and command/status structs for the quote coalescer.
// ----------------------------------------------------------------------------
package quc_pkg;

  localparam int PEND_DEPTH = 32;
  localparam int SENT_DEPTH = 64;
  localparam int PIW = $clog2(PEND_DEPTH);
  localparam int PCW = $clog2(PEND_DEPTH + 1);
  localparam int SIW = $clog2(SENT_DEPTH);
  localparam int SCW = $clog2(SENT_DEPTH + 1);

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] instrument;
    logic        is_quantity;
    logic [30:0] side_type;
    logic [31:0] price_value;
    logic [31:0] quantity_value;
  } quc_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] out_instrument;
    logic        out_is_quantity;
    logic [30:0] out_side_type;
    logic [31:0] out_price;
    logic [31:0] out_quantity;
    logic        last;
  } quc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic           load_item;   // capture input item
    logic [PIW-1:0] pidx;        // pending read address
    logic [SIW-1:0] sidx;        // sent read address
    logic           pend_merge;  // write quantity into entry phit_idx
    logic           pend_push;   // append item at pend_count
    logic           pend_clear;  // zero pend_count
    logic           sent_write;  // write flushed entry into table
    logic           sent_new;    // write at sent_count and bump it
    logic           cap_pend;    // latch pending read data as current entry
    logic           set_phit;    // record pending hit at pidx
    logic           set_shit;    // record sent hit
    logic           clr_hits;
    logic           out_load;    // load output register
    logic           out_drop;    // output is a drop status
    logic           out_last;
  } quc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic           req_type;
    logic           is_quantity;
    logic [PCW-1:0] pend_count;
    logic [SCW-1:0] sent_count;
    logic           pend_match;  // registered pending read matches item
    logic           pend_qzero;
    logic           sent_match;  // registered sent read matches key
    logic           phit;
    logic           shit;
  } quc_sts_t;

endpackage

>>> hdl/quote_update_coalescer.sv
// ----------------------------------------------------------------------------
// quote_update_coalescer
// Queues quote updates, merges quantities, flushes through a last-sent table.
// ----------------------------------------------------------------------------
//  channel | signals                 | direction
//  input   | in_valid/in_stall/in_item | item in
//  output  | out_valid/out_stall/out_item | result out
//
// A quantity add searches the pending queue, then the last-sent table on a miss
// (one memory read per cycle); a flush searches the table once per pending entry.
// rst clears the queue and table counts. A stalled output holds the sequencer.
module quote_update_coalescer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  quc_pkg::quc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output quc_pkg::quc_out_t out_item
);
  import quc_pkg::*;

  quc_cmd_t cmd;
  quc_sts_t sts;

  quc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  quc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .out_reg (out_item)
  );

endmodule

>>> hdl/quc_datapath.sv
// ----------------------------------------------------------------------------
// quc_datapath
// Pending queue and last-sent table memories, item and output registers.
// ----------------------------------------------------------------------------
module quc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  quc_pkg::quc_in_t  in_item,
  input  quc_pkg::quc_cmd_t cmd,
  output quc_pkg::quc_sts_t sts,
  output quc_pkg::quc_out_t out_reg
);
  import quc_pkg::*;

  logic [31:0] pend_inst [PEND_DEPTH];
  logic [31:0] pend_kind [PEND_DEPTH];
  logic [31:0] pend_prc  [PEND_DEPTH];
  logic [31:0] pend_qty  [PEND_DEPTH];
  logic [31:0] sent_inst [SENT_DEPTH];
  logic [30:0] sent_side [SENT_DEPTH];
  logic [31:0] sent_prc  [SENT_DEPTH];
  logic [31:0] sent_qty  [SENT_DEPTH];

  quc_in_t        item;
  logic [PCW-1:0] pend_count;
  logic [SCW-1:0] sent_count;
  logic [31:0]    pr_inst, pr_kind, pr_prc, pr_qty;
  logic [31:0]    sr_inst, sr_prc;
  logic [30:0]    sr_side;
  logic [31:0]    cur_inst, cur_kind, cur_prc, cur_qty;
  logic           phit, shit;
  logic [PIW-1:0] phit_idx;
  logic [31:0]    hit_prc;
  logic [SIW-1:0] sent_hit_idx;
  logic [30:0]    key_side;
  logic [31:0]    key_inst;
  logic [31:0]    push_prc;

  // during a flush the search key is the current entry, otherwise the item
  assign key_inst = item.req_type ? cur_inst : item.instrument;
  assign key_side = item.req_type ? cur_kind[31:1] : item.side_type;

  assign push_prc = !item.is_quantity ? item.price_value : hit_prc;

  // pending memory
  always_ff @(posedge clk) begin
    pr_inst <= pend_inst[cmd.pidx];
    pr_kind <= pend_kind[cmd.pidx];
    pr_prc  <= pend_prc[cmd.pidx];
    pr_qty  <= pend_qty[cmd.pidx];
    if (cmd.pend_merge) begin
      pend_qty[phit_idx] <= item.quantity_value;
    end
    if (cmd.pend_push) begin
      pend_inst[pend_count[PIW-1:0]] <= item.instrument;
      pend_kind[pend_count[PIW-1:0]] <= {item.side_type, item.is_quantity};
      pend_prc[pend_count[PIW-1:0]]  <= push_prc;
      pend_qty[pend_count[PIW-1:0]]  <= item.is_quantity ? item.quantity_value : 32'd0;
    end
  end

  // sent table memory
  always_ff @(posedge clk) begin
    sr_inst <= sent_inst[cmd.sidx];
    sr_side <= sent_side[cmd.sidx];
    sr_prc  <= sent_prc[cmd.sidx];
    if (cmd.sent_write) begin
      sent_inst[cmd.sent_new ? sent_count[SIW-1:0] : sent_hit_idx] <= cur_inst;
      sent_side[cmd.sent_new ? sent_count[SIW-1:0] : sent_hit_idx] <= cur_kind[31:1];
      sent_prc[cmd.sent_new ? sent_count[SIW-1:0] : sent_hit_idx]  <= cur_prc;
      sent_qty[cmd.sent_new ? sent_count[SIW-1:0] : sent_hit_idx]  <= cur_qty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
      sent_count <= '0;
    end else begin
      if (cmd.pend_clear) begin
        pend_count <= '0;
      end else if (cmd.pend_push) begin
        pend_count <= pend_count + PCW'(1);
      end
      if (cmd.sent_write && cmd.sent_new) begin
        sent_count <= sent_count + SCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
    if (cmd.cap_pend) begin
      cur_inst <= pr_inst;
      cur_kind <= pr_kind;
      cur_prc  <= pr_prc;
      cur_qty  <= pr_qty;
    end
    if (cmd.clr_hits) begin
      phit <= 1'b0;
      shit <= 1'b0;
      hit_prc <= '0;
    end else if (cmd.set_phit) begin
      phit     <= 1'b1;
      phit_idx <= cmd.pidx;
      hit_prc  <= pr_prc;
    end else if (cmd.set_shit) begin
      shit         <= 1'b1;
      sent_hit_idx <= cmd.sidx;
      hit_prc      <= sr_prc;
    end
    if (cmd.out_load) begin
      if (cmd.out_drop) begin
        out_reg <= '{status: 1'b1, out_instrument: 32'd0, out_is_quantity: 1'b0,
                     out_side_type: 31'd0, out_price: 32'd0, out_quantity: 32'd0,
                     last: 1'b1};
      end else begin
        out_reg.status          <= 1'b0;
        out_reg.out_instrument  <= cur_inst;
        out_reg.out_is_quantity <= cur_kind[0];
        out_reg.out_side_type   <= cur_kind[31:1];
        out_reg.out_price       <= cur_prc;
        out_reg.out_quantity    <= cur_qty;
        out_reg.last            <= cmd.out_last;
      end
    end
  end

  assign sts.req_type    = item.req_type;
  assign sts.is_quantity = item.is_quantity;
  assign sts.pend_count  = pend_count;
  assign sts.sent_count  = sent_count;
  assign sts.pend_match  = (pr_inst == item.instrument) && (pr_kind[31:1] == item.side_type);
  assign sts.pend_qzero  = (pr_qty == 32'd0);
  assign sts.sent_match  = (sr_inst == key_inst) && (sr_side == key_side);
  assign sts.phit        = phit;
  assign sts.shit        = shit;

endmodule

>>> hdl/quc_ctrl.sv
// ----------------------------------------------------------------------------
// quc_ctrl
// Sequencer: pending search, table search, queue append and flush walk.
// ----------------------------------------------------------------------------
module quc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  quc_pkg::quc_sts_t sts,
  output quc_pkg::quc_cmd_t cmd
);
  import quc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_PSRCH = 4'd2;   // address issued, check next cycle
  localparam logic [3:0] S_SSRCH = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;   // flush: read pending entry
  localparam logic [3:0] S_FCAP  = 4'd6;
  localparam logic [3:0] S_FSRCH = 4'd7;
  localparam logic [3:0] S_FOUT  = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_DROP  = 4'd10;

  logic [3:0]     state, state_next;
  logic [PCW-1:0] pcnt, pcnt_next;    // pending walk index
  logic [SCW-1:0] scnt, scnt_next;    // sent walk index
  logic           ovalid, ovalid_next;
  logic           fdone, fdone_next;  // flush: this was the last entry
  logic           pchk, pchk_next;    // a read result is pending check

  assign out_valid = ovalid;
  assign in_stall  = (state != S_IDLE) || ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      pcnt   <= '0;
      scnt   <= '0;
      fdone  <= 1'b0;
      pchk   <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
      pcnt   <= pcnt_next;
      scnt   <= scnt_next;
      fdone  <= fdone_next;
      pchk   <= pchk_next;
    end
  end

  always_comb begin
    state_next  = state;
    pcnt_next   = pcnt;
    scnt_next   = scnt;
    fdone_next  = fdone;
    pchk_next   = 1'b0;
    ovalid_next = ovalid && out_stall;
    cmd         = '0;
    cmd.pidx    = pcnt[PIW-1:0];
    cmd.sidx    = scnt[SIW-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_item = 1'b1;
          cmd.clr_hits  = 1'b1;
          pcnt_next     = '0;
          scnt_next     = '0;
          state_next    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.req_type == REQ_FLUSH) begin
          state_next = (sts.pend_count == '0) ? S_IDLE : S_FRD;
        end else if (!sts.is_quantity) begin
          state_next = S_DEC;
        end else begin
          state_next = S_PSRCH;
        end
      end
      // pidx = pcnt is read now; its data is checked in the next cycle
      S_PSRCH: begin
        if (pchk && sts.pend_match) begin
          cmd.pidx      = pcnt[PIW-1:0] - PIW'(1);
          cmd.set_phit  = 1'b1;
          if (sts.pend_qzero) begin
            cmd.pend_merge = 1'b0;
          end
          state_next = S_DEC;
        end else if (pcnt == sts.pend_count) begin
          state_next = S_SSRCH;
        end else begin
          pcnt_next = pcnt + PCW'(1);
          pchk_next = 1'b1;
        end
      end
      S_SSRCH: begin
        if (pchk && sts.sent_match) begin
          cmd.sidx     = scnt[SIW-1:0] - SIW'(1);
          cmd.set_shit = 1'b1;
          state_next   = S_DEC;
        end else if (scnt == sts.sent_count) begin
          state_next = S_DEC;
        end else begin
          scnt_next = scnt + SCW'(1);
          pchk_next = 1'b1;
        end
      end
      S_DEC: begin
        // pend_qzero refers to the hit entry when it was latched; recheck by
        // reading the hit address again
        if (sts.is_quantity && sts.phit && !pchk) begin
          cmd.pidx  = pcnt[PIW-1:0] - PIW'(1);
          pchk_next = 1'b1;
        end else if (sts.is_quantity && sts.phit && sts.pend_qzero) begin
          cmd.pend_merge = 1'b1;
          state_next     = S_IDLE;
        end else if (sts.pend_count == PCW'(PEND_DEPTH)) begin
          state_next = S_DROP;
        end else begin
          cmd.pend_push = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DROP: begin
        if (!ovalid || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.out_drop = 1'b1;
          ovalid_next  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FRD: begin
        state_next = S_FCAP;
      end
      S_FCAP: begin
        cmd.cap_pend = 1'b1;
        cmd.clr_hits = 1'b1;
        scnt_next    = '0;
        fdone_next   = (pcnt + PCW'(1) == sts.pend_count);
        state_next   = S_FSRCH;
      end
      S_FSRCH: begin
        if (pchk && sts.sent_match) begin
          cmd.sidx     = scnt[SIW-1:0] - SIW'(1);
          cmd.set_shit = 1'b1;
          state_next   = S_FOUT;
        end else if (scnt == sts.sent_count) begin
          state_next = S_FOUT;
        end else begin
          scnt_next = scnt + SCW'(1);
          pchk_next = 1'b1;
        end
      end
      S_FOUT: begin
        if (!ovalid || !out_stall) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = fdone;
          ovalid_next    = 1'b1;
          cmd.sent_write = sts.shit || (sts.sent_count != SCW'(SENT_DEPTH));
          cmd.sent_new   = !sts.shit;
          pcnt_next      = pcnt + PCW'(1);
          if (fdone) begin
            cmd.pend_clear = 1'b1;
            state_next     = S_WAIT;
          end else begin
            state_next = S_FRD;
          end
        end
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
